// File: rtl/intc_pkg.sv
// package: shared types and constants for the interrupt controller with timers
`timescale 1ns / 1ps

package intc_pkg;

  // item kinds
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_IRQ   = 2'd3;

  // register map
  localparam logic [3:0] REG_VECTOR = 4'd0;
  localparam logic [3:0] REG_ENABLE = 4'd1;
  localparam logic [3:0] REG_STATUS = 4'd2;
  localparam logic [3:0] REG_CTRL0  = 4'd3;
  localparam logic [3:0] REG_COUNT0 = 4'd7;

  localparam int MAX_TIMERS = 4;

  localparam logic [31:0] CTRL_RESET = 32'h0000_ff00;

  // interrupt source raised by each timer
  localparam logic [4:0] TIMER_SRC [MAX_TIMERS] = '{5'd0, 5'd1, 5'd9, 5'd10};

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [3:0]  byte_enable;
    logic [4:0]  irq_source;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic [7:0]  irq_vector;
  } rsp_t;

  typedef struct packed {
    logic tick;
    logic ctrl_we;
    logic count_we;
  } tmr_cmd_t;

endpackage

// File: rtl/interrupt_controller_with_timers_unit.sv
// top level: vectored interrupt controller with prescaled timers
//
//  channel  dir  handshake             word
//  req      in   req_valid/req_ready   intc_pkg::req_t (tick, read, write, request)
//  rsp      out  rsp_valid/rsp_ready   intc_pkg::rsp_t (read data, line, vector)
//
//  one word per cycle while req_ready is high: all state updates in the accepting cycle, result in the next cycle
//  timer start value is one 9x17 multiply straight into the tick counter
//  line and vector come from the registered pending mask, so they track the result
//  req_ready drops only while a result waits and rsp_ready is low
//  reset clears masks and vector, timers stop with prescale 255
`timescale 1ns / 1ps

module interrupt_controller_with_timers_unit #(
  parameter int NUM_TIMERS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  intc_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output intc_pkg::rsp_t   rsp
);

  logic        accept;
  logic [31:0] lane_mask;
  logic [31:0] enable_mask;
  logic [31:0] enable_mask_next;
  logic [31:0] pending_mask;
  logic [31:0] pending_mask_next;
  logic [2:0]  vector_high;
  logic [2:0]  vector_high_next;
  logic [31:0] read_data;
  logic [31:0] read_data_next;
  logic [31:0] expire_bits;
  logic [4:0]  lowest_src;

  logic [31:0]        tmr_ctrl   [NUM_TIMERS];
  logic [15:0]        tmr_count  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] tmr_expire;
  intc_pkg::tmr_cmd_t tmr_cmd    [NUM_TIMERS];

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  assign lane_mask = {{8{req.byte_enable[3]}}, {8{req.byte_enable[2]}},
                      {8{req.byte_enable[1]}}, {8{req.byte_enable[0]}}};

  for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
    always_comb begin
      tmr_cmd[t].tick     = accept && (req.action == intc_pkg::ACT_TICK);
      tmr_cmd[t].ctrl_we  = accept && (req.action == intc_pkg::ACT_WRITE) &&
                            (req.reg_index == 4'(intc_pkg::REG_CTRL0 + t));
      tmr_cmd[t].count_we = accept && (req.action == intc_pkg::ACT_WRITE) &&
                            (req.reg_index == 4'(intc_pkg::REG_COUNT0 + t));
    end

    intc_timer u_timer (
      .clk     (clk),
      .rst     (rst),
      .cmd     (tmr_cmd[t]),
      .wr_data (req.write_data),
      .wr_mask (lane_mask),
      .ctrl    (tmr_ctrl[t]),
      .count   (tmr_count[t]),
      .expire  (tmr_expire[t])
    );
  end

  always_comb begin
    expire_bits = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      if (tmr_expire[t]) begin
        expire_bits[intc_pkg::TIMER_SRC[t]] = 1'b1;
      end
    end
  end

  always_comb begin
    enable_mask_next  = enable_mask;
    pending_mask_next = pending_mask;
    vector_high_next  = vector_high;
    read_data_next    = '0;
    case (req.action)
      intc_pkg::ACT_TICK: begin
        pending_mask_next = pending_mask | (expire_bits & enable_mask);
      end
      intc_pkg::ACT_READ: begin
        case (req.reg_index)
          intc_pkg::REG_VECTOR: read_data_next = {21'd0, vector_high, 8'd0};
          intc_pkg::REG_ENABLE: read_data_next = enable_mask;
          intc_pkg::REG_STATUS: read_data_next = pending_mask;
          default: begin
            for (int t = 0; t < NUM_TIMERS; t++) begin
              if (req.reg_index == 4'(intc_pkg::REG_CTRL0 + t)) begin
                read_data_next = tmr_ctrl[t];
              end
              if (req.reg_index == 4'(intc_pkg::REG_COUNT0 + t)) begin
                read_data_next = {16'd0, tmr_count[t]};
              end
            end
          end
        endcase
      end
      intc_pkg::ACT_WRITE: begin
        if (req.reg_index == intc_pkg::REG_VECTOR) begin
          // acknowledge: byte 0 names the source to clear
          if (req.byte_enable[0]) begin
            pending_mask_next[req.write_data[4:0]] = 1'b0;
          end
          if (req.byte_enable[1]) begin
            vector_high_next = req.write_data[10:8];
          end
        end else if (req.reg_index == intc_pkg::REG_ENABLE) begin
          enable_mask_next  = (enable_mask & ~lane_mask) | (req.write_data & lane_mask);
          pending_mask_next = pending_mask & enable_mask_next;
        end
      end
      intc_pkg::ACT_IRQ: begin
        pending_mask_next[req.irq_source] = pending_mask[req.irq_source] |
                                            enable_mask[req.irq_source];
      end
      default: begin
        read_data_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask  <= '0;
      pending_mask <= '0;
      vector_high  <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (accept) begin
        enable_mask  <= enable_mask_next;
        pending_mask <= pending_mask_next;
        vector_high  <= vector_high_next;
      end
      if (req_ready) begin
        rsp_valid <= req_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= read_data_next;
    end
  end

  // lowest pending source, scanned from the top so the lowest wins
  always_comb begin
    lowest_src = '0;
    for (int i = 31; i >= 0; i--) begin
      if (pending_mask[i]) begin
        lowest_src = 5'(i);
      end
    end
  end

  assign rsp.read_data  = read_data;
  assign rsp.irq_line   = |pending_mask;
  assign rsp.irq_vector = (pending_mask != '0) ? {vector_high, lowest_src} : 8'd0;

  a_pending_enabled : assert property (@(posedge clk) disable iff (rst)
    (pending_mask & ~enable_mask) == '0)
    else $error("pending bit set for a disabled source");

  a_stall_holds_state : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(pending_mask) && $stable(enable_mask) &&
                                $stable(vector_high))
    else $error("interrupt state changed while a result was stalled");

  a_read_only_data : assert property (@(posedge clk) disable iff (rst)
    accept && req.action != intc_pkg::ACT_READ |=> rsp.read_data == '0)
    else $error("read data non-zero for a non-read word");

  a_masked_request : assert property (@(posedge clk) disable iff (rst)
    accept && req.action == intc_pkg::ACT_IRQ && !enable_mask[req.irq_source]
    |=> $stable(pending_mask))
    else $error("disabled request changed the pending mask");

endmodule

// File: rtl/intc_timer.sv
// one prescaled down-counting timer with control word and reload count
`timescale 1ns / 1ps

module intc_timer (
  input  logic               clk,
  input  logic               rst,
  input  intc_pkg::tmr_cmd_t cmd,
  input  logic [31:0]        wr_data,
  input  logic [31:0]        wr_mask,
  output logic [31:0]        ctrl,
  output logic [15:0]        count,
  output logic               expire
);

  logic [24:0] ticks_left;
  logic [24:0] ticks_left_next;
  logic [31:0] ctrl_next;
  logic [15:0] count_next;
  logic [31:0] ctrl_merged;
  logic [7:0]  start_prescale;
  logic [23:0] start_prod;
  logic [24:0] start_ticks;

  assign ctrl_merged = (ctrl & ~wr_mask) | (wr_data & wr_mask);

  // a start during a control write uses the new prescale, a reload the stored one
  assign start_prescale = cmd.ctrl_we ? ctrl_merged[15:8] : ctrl[15:8];

  // 2*(p+1)*(c+1)-1 == {(p+1)*(c+1)-1, 1}
  assign start_prod  = 24'(({1'b0, start_prescale} + 9'd1) * ({1'b0, count} + 17'd1) - 26'd1);
  assign start_ticks = {start_prod, 1'b1};

  assign expire = cmd.tick && ctrl[0] && (ticks_left == '0);

  always_comb begin
    ctrl_next       = ctrl;
    count_next      = count;
    ticks_left_next = ticks_left;
    if (cmd.ctrl_we) begin
      ctrl_next = ctrl_merged;
      if (ctrl_merged[0] != ctrl[0]) begin
        ticks_left_next = ctrl_merged[0] ? start_ticks : '0;
      end
    end else if (cmd.count_we) begin
      count_next = (count & ~wr_mask[15:0]) | (wr_data[15:0] & wr_mask[15:0]);
    end else if (cmd.tick && ctrl[0]) begin
      if (ticks_left != '0) begin
        ticks_left_next = ticks_left - 25'd1;
      end else if (ctrl[1]) begin
        ticks_left_next = start_ticks;
      end else begin
        ctrl_next[0] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl       <= intc_pkg::CTRL_RESET;
      count      <= '0;
      ticks_left <= '0;
    end else begin
      ctrl       <= ctrl_next;
      count      <= count_next;
      ticks_left <= ticks_left_next;
    end
  end

endmodule

// File: verif/testbench.sv
// testbench for the interrupt controller with timers: directed and random words, self-checked
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  intc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  intc_pkg::rsp_t rsp;

  // shadow of the controller state, advanced once per accepted word
  logic [31:0] en_mask;
  logic [31:0] pend_mask;
  logic [2:0]  vec_hi;
  logic [31:0] tmr_ctrl [intc_pkg::MAX_TIMERS];
  logic [15:0] tmr_reload [intc_pkg::MAX_TIMERS];
  logic [24:0] tmr_left [intc_pkg::MAX_TIMERS];

  intc_pkg::rsp_t due_results [$];
  intc_pkg::rsp_t head_rsp;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent = 0;
  int words_by_action [4] = '{0, 0, 0, 0};
  int timer_expiries = 0;
  int results_checked = 0;
  int fail_count = 0;
  int cycle_count = 0;

  interrupt_controller_with_timers_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** interrupt_controller_with_timers_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (due_results.size() == 0) begin
        $error("result word with nothing expected: %h", rsp);
        fail_count++;
      end else begin
        head_rsp = due_results.pop_front();
        results_checked++;
        if (rsp.read_data !== head_rsp.read_data) begin
          $error("read_data: expected %h, got %h", head_rsp.read_data, rsp.read_data);
          fail_count++;
        end
        if (rsp.irq_line !== head_rsp.irq_line) begin
          $error("irq_line: expected %b, got %b", head_rsp.irq_line, rsp.irq_line);
          fail_count++;
        end
        if (rsp.irq_vector !== head_rsp.irq_vector) begin
          $error("irq_vector: expected %h, got %h", head_rsp.irq_vector, rsp.irq_vector);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [4:0] lowest_pending();
    lowest_pending = 5'd0;
    for (int i = 31; i >= 0; i--)
      if (pend_mask[i]) lowest_pending = 5'(i);
  endfunction

  function automatic void raise_source(input logic [4:0] src);
    if (en_mask[src]) pend_mask[src] = 1'b1;
  endfunction

  function automatic void load_timer(input int t);
    tmr_left[t] = 25'((2 * (int'(tmr_ctrl[t][15:8]) + 1) * (int'(tmr_reload[t]) + 1)) - 1);
  endfunction

  // applies one word to the shadow state and returns the result word it should produce
  function automatic intc_pkg::rsp_t step_irq_state(input intc_pkg::req_t w);
    intc_pkg::rsp_t r;
    logic [31:0] lanes;
    logic [31:0] prev;
    int t;
    r = '0;
    lanes = {{8{w.byte_enable[3]}}, {8{w.byte_enable[2]}},
             {8{w.byte_enable[1]}}, {8{w.byte_enable[0]}}};
    case (w.action)
      intc_pkg::ACT_TICK: begin
        // timers handled in order, so simultaneous expiries raise in that order
        for (t = 0; t < intc_pkg::MAX_TIMERS; t++) begin
          if (tmr_ctrl[t][0]) begin
            if (tmr_left[t] != 0) begin
              tmr_left[t] = tmr_left[t] - 25'd1;
            end else begin
              if (tmr_ctrl[t][1]) load_timer(t);
              else tmr_ctrl[t][0] = 1'b0;
              raise_source(intc_pkg::TIMER_SRC[t]);
              timer_expiries++;
            end
          end
        end
      end
      intc_pkg::ACT_READ: begin
        if (w.reg_index == intc_pkg::REG_VECTOR) r.read_data = {21'd0, vec_hi, 8'd0};
        else if (w.reg_index == intc_pkg::REG_ENABLE) r.read_data = en_mask;
        else if (w.reg_index == intc_pkg::REG_STATUS) r.read_data = pend_mask;
        else if (w.reg_index >= intc_pkg::REG_CTRL0 &&
                 w.reg_index < intc_pkg::REG_CTRL0 + intc_pkg::MAX_TIMERS)
          r.read_data = tmr_ctrl[w.reg_index - intc_pkg::REG_CTRL0];
        else if (w.reg_index >= intc_pkg::REG_COUNT0 &&
                 w.reg_index < intc_pkg::REG_COUNT0 + intc_pkg::MAX_TIMERS)
          r.read_data = {16'd0, tmr_reload[w.reg_index - intc_pkg::REG_COUNT0]};
      end
      intc_pkg::ACT_WRITE: begin
        if (w.reg_index == intc_pkg::REG_VECTOR) begin
          if (w.byte_enable[0]) pend_mask[w.write_data[4:0]] = 1'b0;
          if (w.byte_enable[1]) vec_hi = w.write_data[10:8];
        end else if (w.reg_index == intc_pkg::REG_ENABLE) begin
          en_mask = (en_mask & ~lanes) | (w.write_data & lanes);
          pend_mask = pend_mask & en_mask;
        end else if (w.reg_index >= intc_pkg::REG_CTRL0 &&
                     w.reg_index < intc_pkg::REG_CTRL0 + intc_pkg::MAX_TIMERS) begin
          t = int'(w.reg_index - intc_pkg::REG_CTRL0);
          prev = tmr_ctrl[t];
          tmr_ctrl[t] = (prev & ~lanes) | (w.write_data & lanes);
          if (tmr_ctrl[t][0] != prev[0]) begin
            if (tmr_ctrl[t][0]) load_timer(t);
            else tmr_left[t] = '0;
          end
        end else if (w.reg_index >= intc_pkg::REG_COUNT0 &&
                     w.reg_index < intc_pkg::REG_COUNT0 + intc_pkg::MAX_TIMERS) begin
          t = int'(w.reg_index - intc_pkg::REG_COUNT0);
          tmr_reload[t] = (tmr_reload[t] & ~lanes[15:0]) | (w.write_data[15:0] & lanes[15:0]);
        end
      end
      intc_pkg::ACT_IRQ: raise_source(w.irq_source);
      default: ;
    endcase
    r.irq_line = |pend_mask;
    r.irq_vector = (|pend_mask) ? {vec_hi, lowest_pending()} : 8'd0;
    return r;
  endfunction

  function automatic intc_pkg::req_t make_word(input logic [1:0] action,
                                               input logic [3:0] idx,
                                               input logic [31:0] data, input logic [3:0] be,
                                               input logic [4:0] src);
    intc_pkg::req_t w;
    w.action = action;
    w.reg_index = idx;
    w.write_data = data;
    w.byte_enable = be;
    w.irq_source = src;
    return w;
  endfunction

  // valid is left high after acceptance so back-to-back words need no second assignment
  task automatic send_word(input intc_pkg::req_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (!req_ready);
    due_results.push_back(step_irq_state(w));
    words_sent++;
    words_by_action[w.action]++;
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_readback();
    send_word(make_word(intc_pkg::ACT_READ, intc_pkg::REG_VECTOR, '0, '0, '0));
    send_word(make_word(intc_pkg::ACT_READ, intc_pkg::REG_ENABLE, '0, '0, '0));
    send_word(make_word(intc_pkg::ACT_READ, intc_pkg::REG_STATUS, '0, '0, '0));
    send_word(make_word(intc_pkg::ACT_READ, intc_pkg::REG_CTRL0, '0, '0, '0));
    send_word(make_word(intc_pkg::ACT_READ, 4'(intc_pkg::REG_COUNT0 + 3), '0, '0, '0));
    send_word(make_word(intc_pkg::ACT_READ, 4'd15, '0, '0, '0));
    // nothing enabled yet, so the request is dropped
    send_word(make_word(intc_pkg::ACT_IRQ, '0, '0, '0, 5'd5));
  endtask

  task automatic test_enable_and_vector();
    send_word(make_word(intc_pkg::ACT_WRITE, intc_pkg::REG_ENABLE, 32'hffff_ffff, 4'hf, '0));
    send_word(make_word(intc_pkg::ACT_IRQ, '0, '0, '0, 5'd31));
    send_word(make_word(intc_pkg::ACT_IRQ, '0, '0, '0, 5'd0));
    // clear source 0 and take the top vector base: vector reaches 255
    send_word(make_word(intc_pkg::ACT_WRITE, intc_pkg::REG_VECTOR, 32'h0000_0700, 4'h3, '0));
    send_word(make_word(intc_pkg::ACT_READ, intc_pkg::REG_VECTOR, '0, '0, '0));
    send_word(make_word(intc_pkg::ACT_READ, intc_pkg::REG_STATUS, '0, '0, '0));
    send_word(make_word(intc_pkg::ACT_WRITE, intc_pkg::REG_STATUS, 32'hffff_ffff, 4'hf, '0));
    // masking the top byte drops the pending bit with it
    send_word(make_word(intc_pkg::ACT_WRITE, intc_pkg::REG_ENABLE, 32'h0, 4'h8, '0));
    send_word(make_word(intc_pkg::ACT_IRQ, '0, '0, '0, 5'd31));
  endtask

  task automatic test_timer_expiry();
    send_word(make_word(intc_pkg::ACT_WRITE, intc_pkg::REG_ENABLE, 32'h0000_00ff, 4'h1, '0));
    send_word(make_word(intc_pkg::ACT_WRITE, intc_pkg::REG_CTRL0, 32'h0000_0003, 4'h3, '0));
    send_word(make_word(intc_pkg::ACT_WRITE, 4'(intc_pkg::REG_CTRL0 + 1), 32'h0000_0001,
                        4'h3, '0));
    // both timers expire on the second tick; timer 0 reloads, timer 1 stops
    repeat (4) send_word(make_word(intc_pkg::ACT_TICK, '0, '0, '0, '0));
    send_word(make_word(intc_pkg::ACT_WRITE, intc_pkg::REG_COUNT0, 32'h0000_0001, 4'h3, '0));
    send_word(make_word(intc_pkg::ACT_READ, 4'(intc_pkg::REG_CTRL0 + 1), '0, '0, '0));
    send_word(make_word(intc_pkg::ACT_WRITE, intc_pkg::REG_CTRL0, 32'h0, 4'h1, '0));
  endtask

  task automatic test_random_traffic(input int n_words, input int send_pct,
                                     input int recv_pct);
    int goal;
    int pick;
    int t;
    logic [31:0] d;
    goal = words_sent + n_words;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (words_sent < goal) begin
      pick = $urandom_range(99);
      d = $urandom;
      if (pick < 8) begin
        // stop, load a short count, restart with a small prescale
        t = $urandom_range(intc_pkg::MAX_TIMERS - 1);
        send_word(make_word(intc_pkg::ACT_WRITE, 4'(intc_pkg::REG_CTRL0 + t),
                            d & 32'hffff_fffe, 4'h1, '0));
        send_word(make_word(intc_pkg::ACT_WRITE, 4'(intc_pkg::REG_COUNT0 + t),
                            $urandom_range(6), 4'h3, '0));
        d[15:8] = 8'($urandom_range(3));
        d[0] = 1'b1;
        send_word(make_word(intc_pkg::ACT_WRITE, 4'(intc_pkg::REG_CTRL0 + t), d,
                            4'($urandom_range(15)) | 4'h3, '0));
      end else if (pick < 48) begin
        send_word(make_word(intc_pkg::ACT_TICK, 4'($urandom_range(15)), d,
                            4'($urandom_range(15)), 5'($urandom_range(31))));
      end else if (pick < 60) begin
        send_word(make_word(intc_pkg::ACT_READ, 4'($urandom_range(15)), d,
                            4'($urandom_range(15)), 5'($urandom_range(31))));
      end else if (pick < 68) begin
        // acknowledge the source being served
        d[4:0] = lowest_pending();
        send_word(make_word(intc_pkg::ACT_WRITE, intc_pkg::REG_VECTOR, d,
                            4'($urandom_range(15)) | 4'h1, '0));
      end else if (pick < 76) begin
        send_word(make_word(intc_pkg::ACT_WRITE, intc_pkg::REG_ENABLE, d | $urandom,
                            4'($urandom_range(15)), '0));
      end else if (pick < 84) begin
        send_word(make_word(intc_pkg::ACT_WRITE, 4'($urandom_range(15)), d,
                            4'($urandom_range(15)), 5'($urandom_range(31))));
      end else begin
        send_word(make_word(intc_pkg::ACT_IRQ, 4'($urandom_range(15)), d,
                            4'($urandom_range(15)), 5'($urandom_range(31))));
      end
    end
    wait_for_results();
  endtask

  initial begin
    en_mask = '0;
    pend_mask = '0;
    vec_hi = '0;
    for (int t = 0; t < intc_pkg::MAX_TIMERS; t++) begin
      tmr_ctrl[t] = intc_pkg::CTRL_RESET;
      tmr_reload[t] = '0;
      tmr_left[t] = '0;
    end
    send_idle_pct = 18;
    recv_idle_pct = 77;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_readback();
    test_enable_and_vector();
    wait_for_results();
    test_timer_expiry();
    wait_for_results();
    test_random_traffic(640, 18, 77);
    test_random_traffic(640, 77, 18);
    test_random_traffic(640, 0, 0);
    repeat (8) @(posedge clk);
    $display("covered %0d words: %0d ticks, %0d reads, %0d writes, %0d requests",
             words_sent, words_by_action[intc_pkg::ACT_TICK],
             words_by_action[intc_pkg::ACT_READ], words_by_action[intc_pkg::ACT_WRITE],
             words_by_action[intc_pkg::ACT_IRQ]);
    $display("%0d timer expiries predicted, %0d result words checked, %0d failures",
             timer_expiries, results_checked, fail_count);
    if (fail_count == 0) begin
      $display("** interrupt_controller_with_timers_unit: PASSED **");
    end else begin
      $display("** interrupt_controller_with_timers_unit: FAILED **");
    end
    $finish;
  end

endmodule
